// ----- hdl/drsu_pkg.sv -----
// Shared types and codes for the buffer-age damage ring and scissor union.
`timescale 1ns / 1ps
`default_nettype none

package drsu_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ScrW   = 15;
  localparam int unsigned AgeW   = 8;
  localparam int unsigned AccW   = 18;
  localparam int unsigned CfgIdxW = 2;

  localparam logic MODE_FRAME      = 1'b0;
  localparam logic MODE_INVALIDATE = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRACKING_ON   = 2'd2;

  localparam logic [ScrW-1:0] SCREEN_WIDTH_RST  = 15'd1920;
  localparam logic [ScrW-1:0] SCREEN_HEIGHT_RST = 15'd1080;

  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CoordW-1:0]        w;
    logic [CoordW-1:0]        h;
  } box_t;

  typedef struct packed {
    acc_t x1;
    acc_t y1;
    acc_t x2;
    acc_t y2;
  } rect_t;

endpackage

`default_nettype wire

// ----- hdl/damage_ring_scissor_union.sv -----
// Top level: damage history ring, iterative union unit and scissor clamp.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  config   | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//  input    | in_valid_i / in_ready_o  | mode_i, buffer_age_i, dirty_valid_i, dirty_*_i
//  output   | out_valid_o / out_ready_i| scissor_en_o, scissor_*_o
//
// A tracked frame with buffer age a from 1 to RING_DEPTH starts from its own dirty box
// and merges the a - 1 previous ring entries, one per union step, then one clamp step.
// Every other request goes straight to the clamp step.
// The input is ready only in the idle state, entered when the clamp step loads the
// output register; the clamp step waits while that register is full and not taken.
// Reset empties the ring, clears the write index and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module damage_ring_scissor_union #(
  parameter int unsigned RING_DEPTH = 6
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [drsu_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [drsu_pkg::ScrW-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              mode_i,
  input  wire logic [drsu_pkg::AgeW-1:0]         buffer_age_i,
  input  wire logic                              dirty_valid_i,
  input  wire logic signed [drsu_pkg::CoordW-1:0] dirty_left_i,
  input  wire logic signed [drsu_pkg::CoordW-1:0] dirty_top_i,
  input  wire logic signed [drsu_pkg::CoordW-1:0] dirty_right_i,
  input  wire logic signed [drsu_pkg::CoordW-1:0] dirty_bottom_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   scissor_en_o,
  output logic [drsu_pkg::ScrW-1:0]              scissor_x_o,
  output logic [drsu_pkg::ScrW-1:0]              scissor_y_o,
  output logic [drsu_pkg::ScrW-1:0]              scissor_width_o,
  output logic [drsu_pkg::ScrW-1:0]              scissor_height_o,
  output logic [drsu_pkg::ScrW-1:0]              scissor_y_bottom_o
);
  import drsu_pkg::*;

  localparam int unsigned IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);
  localparam logic [AgeW-1:0] MaxAge  = AgeW'(RING_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UNION,
    S_FINISH
  } state_e;

  state_e            state_q;
  logic [ScrW-1:0]   screen_width_q;
  logic [ScrW-1:0]   screen_height_q;
  logic              tracking_on_q;
  box_t              ring_q [RING_DEPTH];
  logic [IdxW-1:0]   write_idx_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [IdxW-1:0]   remaining_q;
  logic              calc_q;
  rect_t             acc_q;
  rect_t             acc_d;
  logic              out_valid_q;
  logic              use_q;
  logic [ScrW-1:0]   x_q;
  logic [ScrW-1:0]   y_q;
  logic [ScrW-1:0]   w_q;
  logic [ScrW-1:0]   h_q;
  logic [ScrW-1:0]   yb_q;

  logic              in_accept;
  logic              age_in_range;
  logic              do_push;
  box_t              push_box;
  box_t              cur_box;
  box_t              full_box;
  rect_t             cur_rect;
  box_t              rd_box;
  acc_t              rd_ex;
  acc_t              rd_ey;
  acc_t              rd_x;
  acc_t              rd_y;
  logic              rd_empty;
  acc_t              sw_acc;
  acc_t              sh_acc;
  acc_t              cx1;
  acc_t              cy1;
  acc_t              cx2;
  acc_t              cy2;
  acc_t              cw;
  acc_t              ch;
  acc_t              cyb;
  logic              use_d;
  logic              out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign age_in_range = (buffer_age_i != '0) && (buffer_age_i <= MaxAge);

  always_comb begin
    full_box.x = '0;
    full_box.y = '0;
    full_box.w = {1'b0, screen_width_q};
    full_box.h = {1'b0, screen_height_q};
    if (dirty_valid_i) begin
      cur_box.x = dirty_left_i;
      cur_box.y = dirty_top_i;
      cur_box.w = CoordW'(dirty_right_i - dirty_left_i);
      cur_box.h = CoordW'(dirty_bottom_i - dirty_top_i);
    end else begin
      cur_box = full_box;
    end
    cur_rect.x1 = AccW'(cur_box.x);
    cur_rect.y1 = AccW'(cur_box.y);
    cur_rect.x2 = AccW'(cur_box.x) + acc_t'({2'b00, cur_box.w});
    cur_rect.y2 = AccW'(cur_box.y) + acc_t'({2'b00, cur_box.h});
    do_push  = in_accept && (mode_i == MODE_FRAME) && tracking_on_q;
    push_box = age_in_range ? cur_box : full_box;
  end

  // Shared union unit: merges one ring entry into the running bounds per cycle.
  always_comb begin
    rd_box   = ring_q[rd_idx_q];
    rd_x     = AccW'(rd_box.x);
    rd_y     = AccW'(rd_box.y);
    rd_ex    = rd_x + acc_t'({2'b00, rd_box.w});
    rd_ey    = rd_y + acc_t'({2'b00, rd_box.h});
    rd_empty = (rd_box.w == '0) || (rd_box.h == '0);
    acc_d    = acc_q;
    if (!rd_empty) begin
      if (rd_x < acc_q.x1) begin
        acc_d.x1 = rd_x;
      end
      if (rd_y < acc_q.y1) begin
        acc_d.y1 = rd_y;
      end
      if (rd_ex > acc_q.x2) begin
        acc_d.x2 = rd_ex;
      end
      if (rd_ey > acc_q.y2) begin
        acc_d.y2 = rd_ey;
      end
    end
  end

  always_comb begin
    sw_acc = acc_t'({3'b000, screen_width_q});
    sh_acc = acc_t'({3'b000, screen_height_q});
    cx1    = (acc_q.x1 < 0) ? '0 : acc_q.x1;
    cy1    = (acc_q.y1 < 0) ? '0 : acc_q.y1;
    cx2    = (acc_q.x2 > sw_acc) ? sw_acc : acc_q.x2;
    cy2    = (acc_q.y2 > sh_acc) ? sh_acc : acc_q.y2;
    cw     = cx2 - cx1;
    ch     = cy2 - cy1;
    cyb    = sh_acc - cy2;
    use_d  = calc_q && (cw > 0) && (ch > 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
      tracking_on_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        CFG_TRACKING_ON:   tracking_on_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      write_idx_q <= '0;
    end else if (in_accept && (mode_i == MODE_INVALIDATE)) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      write_idx_q <= '0;
    end else if (do_push) begin
      ring_q[write_idx_q] <= push_box;
      write_idx_q         <= (write_idx_q == LastIdx) ? '0 : write_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      calc_q      <= 1'b0;
      rd_idx_q    <= '0;
      remaining_q <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      use_q       <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      w_q         <= '0;
      h_q         <= '0;
      yb_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            acc_q    <= cur_rect;
            rd_idx_q <= (write_idx_q == '0) ? LastIdx : write_idx_q - 1'b1;
            remaining_q <= IdxW'(buffer_age_i - 8'd1);
            calc_q   <= do_push && age_in_range;
            if (do_push && age_in_range && (buffer_age_i != 8'd1)) begin
              state_q <= S_UNION;
            end else begin
              state_q <= S_FINISH;
            end
          end
        end
        S_UNION: begin
          acc_q       <= acc_d;
          rd_idx_q    <= (rd_idx_q == '0) ? LastIdx : rd_idx_q - 1'b1;
          remaining_q <= remaining_q - 1'b1;
          if (remaining_q == IdxW'(1)) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            use_q       <= use_d;
            x_q         <= use_d ? ScrW'(cx1) : '0;
            y_q         <= use_d ? ScrW'(cy1) : '0;
            w_q         <= use_d ? ScrW'(cw) : '0;
            h_q         <= use_d ? ScrW'(ch) : '0;
            yb_q        <= use_d ? ScrW'(cyb) : '0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scissor_en_o       = use_q;
  assign scissor_x_o        = x_q;
  assign scissor_y_o        = y_q;
  assign scissor_width_o    = w_q;
  assign scissor_height_o   = h_q;
  assign scissor_y_bottom_o = yb_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (write_idx_q <= LastIdx) && (rd_idx_q <= LastIdx))
    else $error("Ring index out of range.");

  a_union_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UNION) |-> (remaining_q != '0))
    else $error("Union step entered with no entries left.");

  a_invalidate_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (mode_i == MODE_INVALIDATE)) |=> (write_idx_q == '0))
    else $error("Invalidate did not reset the write index.");

  a_no_scissor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !scissor_en_o) |->
      ((scissor_width_o == '0) && (scissor_height_o == '0) && (scissor_x_o == '0)))
    else $error("Result without scissor carries nonzero fields.");

  a_scissor_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scissor_en_o) |->
      ((scissor_width_o != '0) && (scissor_height_o != '0)))
    else $error("Scissor given with empty extent.");

endmodule

`default_nettype wire
